### design/dudc_pkg.sv
// Shared types and constants for the differential uniformity checker.
`timescale 1ns / 1ps

package dudc_pkg;

  localparam int unsigned IN_BITS_DEF  = 8;
  localparam int unsigned OUT_BITS_DEF = 8;
  localparam int unsigned FIELD_W      = 8;
  localparam int unsigned BOUND_W      = 9;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 9'd4;
  localparam int unsigned PAIR_INC     = 2;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ROW  = 2'd1,
    CMD_ALL  = 2'd2
  } dudc_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RDA,
    ST_RDB,
    ST_CRD,
    ST_UPD
  } dudc_state_e;

  typedef struct packed {
    logic clr;
    logic upd;
  } cnt_op_t;

endpackage

### design/dudc_sbox_ram.sv
// S-box storage: one write port, one registered read port.
`timescale 1ns / 1ps

module dudc_sbox_ram #(
  parameter int unsigned AW = dudc_pkg::IN_BITS_DEF,
  parameter int unsigned DW = dudc_pkg::OUT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/dudc_count_unit.sv
// Row counter memory with the shared add-two and bound compare.
`timescale 1ns / 1ps

module dudc_count_unit #(
  parameter int unsigned IN_BITS  = dudc_pkg::IN_BITS_DEF,
  parameter int unsigned OUT_BITS = dudc_pkg::OUT_BITS_DEF
) (
  input  logic                          clk_i,
  input  dudc_pkg::cnt_op_t             op_i,
  input  logic [OUT_BITS-1:0]           addr_i,
  input  logic [dudc_pkg::BOUND_W-1:0]  bound_i,
  output logic                          over_o
);

  // A count reaches at most 2^IN_BITS.
  localparam int unsigned CntW = IN_BITS + 1;
  localparam int unsigned CmpW = (CntW > dudc_pkg::BOUND_W) ? CntW : dudc_pkg::BOUND_W;

  logic [CntW-1:0] mem [2**OUT_BITS];
  logic [CntW-1:0] rdata_q;
  logic [CntW-1:0] sum;
  logic [CntW-1:0] wdata;

  assign sum    = rdata_q + CntW'(dudc_pkg::PAIR_INC);
  assign over_o = CmpW'(sum) > CmpW'(bound_i);
  assign wdata  = op_i.clr ? '0 : sum;

  always_ff @(posedge clk_i) begin
    if (op_i.clr || op_i.upd) begin
      mem[addr_i] <= wdata;
    end
    rdata_q <= mem[addr_i];
  end

endmodule

### design/dudc_seq.sv
// Sequencer: row and pair cursors, table reads, counter updates, result.
`timescale 1ns / 1ps

module dudc_seq #(
  parameter int unsigned IN_BITS  = dudc_pkg::IN_BITS_DEF,
  parameter int unsigned OUT_BITS = dudc_pkg::OUT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    cmd_i,
  input  logic [dudc_pkg::FIELD_W-1:0]  delta_i,
  input  logic [dudc_pkg::BOUND_W-1:0]  bound_i,
  input  logic [OUT_BITS-1:0]           sbox_rdata_i,
  output logic [IN_BITS-1:0]            sbox_raddr_o,
  output dudc_pkg::cnt_op_t             cnt_op_o,
  output logic [OUT_BITS-1:0]           cnt_addr_o,
  input  logic                          cnt_over_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          passes_o
);

  localparam int unsigned InSize = 2**IN_BITS;
  localparam int unsigned ExtW   = (IN_BITS > dudc_pkg::FIELD_W) ? IN_BITS : dudc_pkg::FIELD_W;
  localparam int unsigned HbW    = (IN_BITS > 1) ? $clog2(IN_BITS) : 1;
  localparam logic [IN_BITS-1:0] LastPair = IN_BITS'(InSize / 2 - 1);

  dudc_pkg::dudc_state_e state_q, state_d;
  logic [IN_BITS-1:0]  row_q, row_d;
  logic                all_q, all_d;
  logic [HbW-1:0]      hb_q, hb_d;
  logic [OUT_BITS-1:0] clr_q, clr_d;
  logic [IN_BITS-1:0]  pair_q, pair_d;
  logic [OUT_BITS-1:0] sa_q, sa_d;
  logic [OUT_BITS-1:0] diff_q, diff_d;
  logic                done_q, done_d;
  logic                pass_q, pass_d;

  logic [ExtW-1:0]     delta_ext;
  logic                delta_beyond;
  logic                row0_pass;
  logic [IN_BITS-1:0]  lo_mask;
  logic [IN_BITS-1:0]  x;
  logic [OUT_BITS-1:0] diff;

  assign delta_ext    = ExtW'(delta_i);
  assign delta_beyond = (delta_ext >> IN_BITS) != '0;
  assign row0_pass    = 32'(bound_i) >= 32'(InSize);

  // Highest set bit of the row difference splits each pair.
  always_comb begin
    hb_d = '0;
    for (int i = 0; i < IN_BITS; i++) begin
      if (row_q[i]) hb_d = HbW'(i);
    end
  end

  // Insert a zero at bit hb of the pair number to get the lower member.
  assign lo_mask = ~({IN_BITS{1'b1}} << hb_q);
  assign x       = ((pair_q & ~lo_mask) << 1) | (pair_q & lo_mask);
  assign diff    = sa_q ^ sbox_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dudc_pkg::ST_IDLE;
      row_q   <= '0;
      all_q   <= 1'b0;
      hb_q    <= '0;
      clr_q   <= '0;
      pair_q  <= '0;
      sa_q    <= '0;
      diff_q  <= '0;
      done_q  <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      all_q   <= all_d;
      hb_q    <= hb_d;
      clr_q   <= clr_d;
      pair_q  <= pair_d;
      sa_q    <= sa_d;
      diff_q  <= diff_d;
      done_q  <= done_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    all_d        = all_q;
    clr_d        = clr_q;
    pair_d       = pair_q;
    sa_d         = sa_q;
    diff_d       = diff_q;
    done_d       = 1'b0;
    pass_d       = pass_q;
    cnt_op_o     = '0;
    cnt_addr_o   = clr_q;
    sbox_raddr_o = x;
    unique case (state_q)
      dudc_pkg::ST_IDLE: begin
        if (accept_i) begin
          unique case (dudc_pkg::dudc_cmd_e'(cmd_i))
            dudc_pkg::CMD_ROW: begin
              if (delta_i == '0) begin
                done_d = 1'b1;
                pass_d = row0_pass;
              end else if (delta_beyond) begin
                done_d = 1'b1;
                pass_d = 1'b1;
              end else begin
                row_d   = delta_ext[IN_BITS-1:0];
                all_d   = 1'b0;
                clr_d   = '0;
                state_d = dudc_pkg::ST_CLEAR;
              end
            end
            dudc_pkg::CMD_ALL: begin
              row_d   = IN_BITS'(1);
              all_d   = 1'b1;
              clr_d   = '0;
              state_d = dudc_pkg::ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      dudc_pkg::ST_CLEAR: begin
        cnt_op_o.clr = 1'b1;
        if (clr_q == '1) begin
          pair_d  = '0;
          state_d = dudc_pkg::ST_RDA;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      dudc_pkg::ST_RDA: begin
        state_d = dudc_pkg::ST_RDB;
      end
      dudc_pkg::ST_RDB: begin
        sbox_raddr_o = x ^ row_q;
        sa_d         = sbox_rdata_i;
        state_d      = dudc_pkg::ST_CRD;
      end
      dudc_pkg::ST_CRD: begin
        cnt_addr_o = diff;
        diff_d     = diff;
        state_d    = dudc_pkg::ST_UPD;
      end
      dudc_pkg::ST_UPD: begin
        cnt_op_o.upd = 1'b1;
        cnt_addr_o   = diff_q;
        if (cnt_over_i) begin
          done_d  = 1'b1;
          pass_d  = 1'b0;
          state_d = dudc_pkg::ST_IDLE;
        end else if (pair_q == LastPair) begin
          if (all_q && (row_q != '1)) begin
            row_d   = row_q + 1'b1;
            clr_d   = '0;
            state_d = dudc_pkg::ST_CLEAR;
          end else begin
            done_d  = 1'b1;
            pass_d  = 1'b1;
            state_d = dudc_pkg::ST_IDLE;
          end
        end else begin
          pair_d  = pair_q + 1'b1;
          state_d = dudc_pkg::ST_RDA;
        end
      end
      default: state_d = dudc_pkg::ST_IDLE;
    endcase
  end

  assign busy_o   = state_q != dudc_pkg::ST_IDLE;
  assign done_o   = done_q;
  assign passes_o = pass_q;

endmodule

### design/differential_uniformity_checker.sv
// Top level of the S-box differential uniformity checker.
`timescale 1ns / 1ps

// Commands are taken when start is high and busy is low; the pass/fail answer
// of a test appears on passes_o when done_o is high for one cycle and cannot be
// held off. A load gives no answer. A row test of row zero or of a difference
// beyond the table answers in the next cycle. Any other row test first clears
// the 2^OUT_BITS row counters (one per cycle), then walks the 2^(IN_BITS-1)
// input pairs, each through the states RDA, RDB, CRD and UPD, via the single
// S-box read port and the single counter read-modify-write port, and stops
// early when a counter goes over the bound. A whole-table test repeats this
// for rows 1 to 2^IN_BITS-1 and stops at the first failing row.
module differential_uniformity_checker #(
  parameter int unsigned IN_BITS  = dudc_pkg::IN_BITS_DEF,
  parameter int unsigned OUT_BITS = dudc_pkg::OUT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [dudc_pkg::FIELD_W-1:0]  entry_index_i,
  input  logic [dudc_pkg::FIELD_W-1:0]  entry_value_i,
  input  logic [dudc_pkg::FIELD_W-1:0]  delta_i,
  output logic                          done_o,
  output logic                          passes_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dudc_pkg::BOUND_W-1:0]  cfg_bound_i
);

  localparam int unsigned IdxW = (IN_BITS > dudc_pkg::FIELD_W) ? IN_BITS : dudc_pkg::FIELD_W;
  localparam int unsigned ValW = (OUT_BITS > dudc_pkg::FIELD_W) ? OUT_BITS : dudc_pkg::FIELD_W;

  logic [dudc_pkg::BOUND_W-1:0] bound_q;
  logic                         accept;
  logic                         load_we;
  logic [IdxW-1:0]              index_ext;
  logic [ValW-1:0]              value_ext;
  logic [IN_BITS-1:0]           sbox_raddr;
  logic [OUT_BITS-1:0]          sbox_rdata;
  dudc_pkg::cnt_op_t            cnt_op;
  logic [OUT_BITS-1:0]          cnt_addr;
  logic                         cnt_over;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign load_we     = accept && (cmd_i == dudc_pkg::CMD_LOAD);
  assign index_ext   = IdxW'(entry_index_i);
  assign value_ext   = ValW'(entry_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= dudc_pkg::BOUND_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bound_q <= cfg_bound_i;
    end
  end

  dudc_sbox_ram #(
    .AW (IN_BITS),
    .DW (OUT_BITS)
  ) u_sbox (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (index_ext[IN_BITS-1:0]),
    .wdata_i (value_ext[OUT_BITS-1:0]),
    .raddr_i (sbox_raddr),
    .rdata_o (sbox_rdata)
  );

  dudc_count_unit #(
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_count (
    .clk_i   (clk_i),
    .op_i    (cnt_op),
    .addr_i  (cnt_addr),
    .bound_i (bound_q),
    .over_o  (cnt_over)
  );

  dudc_seq #(
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .delta_i      (delta_i),
    .bound_i      (bound_q),
    .sbox_rdata_i (sbox_rdata),
    .sbox_raddr_o (sbox_raddr),
    .cnt_op_o     (cnt_op),
    .cnt_addr_o   (cnt_addr),
    .cnt_over_i   (cnt_over),
    .busy_o       (busy),
    .done_o       (done_o),
    .passes_o     (passes_o)
  );

  // An answer only shows once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // Going busy needs an accepted test command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) &&
      ($past(cmd_i) == dudc_pkg::CMD_ROW || $past(cmd_i) == dudc_pkg::CMD_ALL))
    else $error("busy without a test command");

  // Every test that ran ends with an answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("test ended without a result");

  // Counters are never touched by clear and update together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cnt_op.clr && cnt_op.upd))
    else $error("counter clear and update collide");

endmodule

### tb/tb.sv
// Self-checking testbench for the S-box differential uniformity checker.
`timescale 1ns / 1ps

module tb;

  typedef logic [dudc_pkg::FIELD_W-1:0] field_t;
  typedef logic [dudc_pkg::BOUND_W-1:0] bound_t;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         TABLE_SIZE   = 1 << dudc_pkg::IN_BITS_DEF;
  localparam int         OUT_SIZE     = 1 << dudc_pkg::OUT_BITS_DEF;
  localparam int         RANDOM_ITEMS = 50;
  localparam int         DRAIN_LIMIT  = 400000;
  localparam int         ALL_ROWS_CAP = 12;

  typedef struct {
    logic       passes;
    logic [1:0] op;
    field_t     delta;
  } verdict_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start         = 1'b0;
  logic       busy;
  logic [1:0] cmd_i         = dudc_pkg::CMD_LOAD;
  field_t     entry_index_i = '0;
  field_t     entry_value_i = '0;
  field_t     delta_i       = '0;
  logic       done_o;
  logic       passes_o;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  bound_t     cfg_bound_i   = '0;

  // Shadow of the block: S-box contents and the bound register.
  logic [dudc_pkg::OUT_BITS_DEF-1:0] sbox_q [TABLE_SIZE];
  bound_t                            bound_q = dudc_pkg::BOUND_RESET;
  verdict_t                          verdicts_q [$];
  int                                mismatch_count = 0;

  differential_uniformity_checker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .delta_i       (delta_i),
    .done_o        (done_o),
    .passes_o      (passes_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_bound_i   (cfg_bound_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit row_passes(input field_t d);
    int hits [OUT_SIZE];
    int hb;
    logic [dudc_pkg::OUT_BITS_DEF-1:0] diff;
    foreach (hits[i]) hits[i] = 0;
    hb = 0;
    for (int b = 0; b < dudc_pkg::IN_BITS_DEF; b++) begin
      if (d[b]) hb = b;
    end
    for (int x = 0; x < TABLE_SIZE; x++) begin
      // take each pair {x, x^d} once: skip x with the top bit of d set
      if (((x >> hb) & 1) != 0) continue;
      diff = sbox_q[x] ^ sbox_q[x ^ int'(d)];
      hits[diff] += int'(dudc_pkg::PAIR_INC);
      if (hits[diff] > int'(bound_q)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit single_row_passes(input field_t d);
    if (d == '0) return (TABLE_SIZE <= int'(bound_q));
    if (int'(d) >= TABLE_SIZE) return 1'b1;
    return row_passes(d);
  endfunction

  function automatic bit table_passes(output int rows);
    rows = 0;
    for (int r = 1; r < TABLE_SIZE; r++) begin
      rows = r;
      if (!row_passes(field_t'(r))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = x[7] ? ((x << 1) ^ 8'h1B) : (x << 1);
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic model_step(input logic [1:0] op, input field_t idx,
                            input field_t val, input field_t d);
    verdict_t v;
    int rows;
    v.op    = op;
    v.delta = d;
    case (op)
      dudc_pkg::CMD_LOAD:
        sbox_q[idx[dudc_pkg::IN_BITS_DEF-1:0]] = val[dudc_pkg::OUT_BITS_DEF-1:0];
      dudc_pkg::CMD_ROW: begin
        v.passes   = single_row_passes(d);
        verdicts_q = {verdicts_q, v};
      end
      dudc_pkg::CMD_ALL: begin
        v.passes   = table_passes(rows);
        verdicts_q = {verdicts_q, v};
      end
      default: ;
    endcase
  endtask

  // Call at a rising edge; returns at the edge that accepts the item with start
  // still high, so a back-to-back item keeps it high.
  task automatic send_item(input logic [1:0] op, input field_t idx,
                           input field_t val, input field_t d,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= op;
    entry_index_i <= idx;
    entry_value_i <= val;
    delta_i       <= d;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    model_step(op, idx, val, d);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk_i);
      waited++;
    end while ((verdicts_q.size() != 0 || busy) && waited < DRAIN_LIMIT);
    if (verdicts_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", verdicts_q.size()));
      verdicts_q.delete();
    end
    // a load gives no result; let it finish
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bound(input bound_t value);
    drain_results();
    repeat ($urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_bound_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bound_q = value;
  endtask

  task automatic send_row(input field_t d);
    send_item(dudc_pkg::CMD_ROW, field_t'($urandom_range(0, 255)),
              field_t'($urandom_range(0, 255)), d, pick_gap());
  endtask

  task automatic send_all();
    send_item(dudc_pkg::CMD_ALL, field_t'($urandom_range(0, 255)),
              field_t'($urandom_range(0, 255)), field_t'($urandom_range(0, 255)),
              pick_gap());
  endtask

  always @(negedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && done_o) begin
      if (verdicts_q.size() == 0) begin
        report_mismatch($sformatf("result passes=%0b with nothing pending", passes_o));
      end else begin
        want = verdicts_q.pop_front();
        if (passes_o !== want.passes)
          report_mismatch($sformatf("cmd %0d delta %0d: passes %b, want %b",
                                    want.op, want.delta, passes_o, want.passes));
      end
    end
  end

  // Row zero needs no table: it compares the table size with the bound.
  task automatic test_row_zero();
    send_row('0);
    write_bound(9'd256);
    send_row('0);
    write_bound(9'd255);
    send_row('0);
    write_bound(9'd511);
    send_row('0);
    write_bound(9'd0);
    send_row('0);
    write_bound(9'd257);
    send_row('0);
    drain_results();
  endtask

  task automatic test_ignored_cmd();
    send_item(CMD_UNUSED, field_t'($urandom_range(0, 255)),
              field_t'($urandom_range(0, 255)), field_t'($urandom_range(0, 255)), 0);
    send_item(CMD_UNUSED, field_t'($urandom_range(0, 255)),
              field_t'($urandom_range(0, 255)), 8'd0, 0);
    send_row('0);
    drain_results();
  endtask

  // Identity box: every row maps all pairs to one difference, count 256.
  task automatic test_identity_box();
    for (int i = 0; i < TABLE_SIZE; i++)
      send_item(dudc_pkg::CMD_LOAD, field_t'(i), field_t'(i),
                field_t'($urandom_range(0, 255)), pick_gap());
    write_bound(9'd256);
    send_row(8'h01);
    send_row(8'h80);
    send_row(8'hFF);
    write_bound(9'd255);
    send_row(8'h55);
    send_all();
    drain_results();
  endtask

  // Cube map in GF(2^8) is almost perfect nonlinear: bound two is the edge.
  task automatic test_cube_box();
    for (int i = TABLE_SIZE - 1; i >= 0; i--)
      send_item(dudc_pkg::CMD_LOAD, field_t'(i), gf_mul(i[7:0], gf_mul(i[7:0], i[7:0])),
                field_t'($urandom_range(0, 255)), pick_gap());
    write_bound(9'd2);
    send_row(8'h01);
    send_row(8'hA5);
    send_all();
    write_bound(9'd3);
    send_row(8'h3C);
    write_bound(9'd1);
    send_row(8'h02);
    send_all();
    write_bound(9'd0);
    send_all();
    drain_results();
  endtask

  task automatic test_random_mix();
    logic [1:0] op;
    field_t     idx;
    field_t     val;
    field_t     d;
    bound_t     bnd;
    bit         quiet;
    int         r;
    int         rows;
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 10 == 0) begin
        case ($urandom_range(0, 7))
          0: bnd = 9'd2;
          1: bnd = bound_t'($urandom_range(0, 5));
          2: bnd = bound_t'($urandom_range(6, 16));
          3: bnd = 9'd256;
          4: bnd = 9'd511;
          5: bnd = bound_t'($urandom_range(0, 511));
          6: bnd = 9'd4;
          default: bnd = 9'd8;
        endcase
        write_bound(bnd);
        quiet = ($urandom_range(0, 3) == 0);
      end
      r   = $urandom_range(0, 99);
      idx = field_t'($urandom_range(0, 255));
      val = field_t'($urandom_range(0, 255));
      d   = field_t'($urandom_range(0, 255));
      if (r < 50) begin
        op = dudc_pkg::CMD_LOAD;
      end else if (r < 88) begin
        op = dudc_pkg::CMD_ROW;
        if (r < 53) d = '0;
      end else if (r < 95) begin
        op = dudc_pkg::CMD_ALL;
        // keep whole-table scans short: demote those that would run long
        if (table_passes(rows) || rows > ALL_ROWS_CAP) op = dudc_pkg::CMD_ROW;
      end else begin
        op = CMD_UNUSED;
      end
      send_item(op, idx, val, d, quiet ? 0 : pick_gap());
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_row_zero();
    test_ignored_cmd();
    test_identity_box();
    test_cube_box();
    test_random_mix();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
